@@ design/scc_pkg.sv @@
// shared types and constants for the segment clipper
package scc_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int OUT_BITS   = 24;
    localparam int IDX_BITS   = 4;
    localparam int CNT_BITS   = 5;

    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int V_BITS     = PROD_BITS + 1;
    localparam int MAG_BITS   = PROD_BITS;
    localparam int HALF_BITS  = MAG_BITS / 2;
    localparam int CPROD_BITS = 2 * MAG_BITS;
    localparam int DEN_BITS   = MAG_BITS + 1;
    localparam int FMUL_BITS  = DIFF_BITS + HALF_BITS;
    localparam int FMAG_BITS  = DIFF_BITS + MAG_BITS;
    localparam int NUM_BITS   = FMAG_BITS + FRAC_BITS + 2;
    localparam int QUO_BITS   = DIFF_BITS + FRAC_BITS + 1;

    localparam logic REQ_VERTEX = 1'b0;
    localparam logic REQ_CLIP   = 1'b1;

    localparam logic [CNT_BITS-1:0] MIN_VERTICES = 5'd3;

    typedef struct packed {
        logic                         clip;
        logic                         slot_ok;
        logic [IDX_BITS-1:0]          slot;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [DIFF_BITS-1:0]  dx;
        logic signed [DIFF_BITS-1:0]  dy;
    } scc_item_t;

endpackage

@@ design/scc_front.sv @@
// front end: accepts request beats and classifies them for the queue
module scc_front #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  req_type,
    input  logic [scc_pkg::IDX_BITS-1:0]          vertex_index,
    input  logic signed [scc_pkg::COORD_BITS-1:0] vertex_x,
    input  logic signed [scc_pkg::COORD_BITS-1:0] vertex_y,
    input  logic signed [scc_pkg::COORD_BITS-1:0] start_x,
    input  logic signed [scc_pkg::COORD_BITS-1:0] start_y,
    input  logic signed [scc_pkg::COORD_BITS-1:0] end_x,
    input  logic signed [scc_pkg::COORD_BITS-1:0] end_y,
    output logic                                  push_valid,
    input  logic                                  push_ready,
    output scc_pkg::scc_item_t                    push_item
);
    import scc_pkg::*;

    logic is_clip;

    assign is_clip    = (req_type == REQ_CLIP);
    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    always_comb
    begin
        push_item.clip    = is_clip;
        push_item.slot_ok = ({28'd0, vertex_index} < 32'(MAX_VERTICES));
        push_item.slot    = vertex_index;
        push_item.x       = is_clip ? start_x : vertex_x;
        push_item.y       = is_clip ? start_y : vertex_y;
        push_item.dx      = DIFF_BITS'(end_x) - DIFF_BITS'(start_x);
        push_item.dy      = DIFF_BITS'(end_y) - DIFF_BITS'(start_y);
    end

endmodule

@@ design/scc_fifo.sv @@
// two-entry queue between the front end and the clip engine
module scc_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  scc_pkg::scc_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output scc_pkg::scc_item_t pop_item
);
    import scc_pkg::*;

    scc_item_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ design/scc_back.sv @@
// clip engine: vertex table, edge loop, fraction compares and fixed-point divides
module scc_back #(
    parameter int MAX_VERTICES = 16,
    parameter int AW           = 4,
    parameter int CW           = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pop_valid,
    output logic                                 pop_ready,
    input  scc_pkg::scc_item_t                   pop_item,
    input  logic [CW-1:0]                        n_edges,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 visible,
    output logic signed [scc_pkg::OUT_BITS-1:0]  clip_start_x,
    output logic signed [scc_pkg::OUT_BITS-1:0]  clip_start_y,
    output logic signed [scc_pkg::OUT_BITS-1:0]  clip_end_x,
    output logic signed [scc_pkg::OUT_BITS-1:0]  clip_end_y
);
    import scc_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_START    = 16'h0002,
        S_LOAD0    = 16'h0004,
        S_EDGE_RD  = 16'h0008,
        S_EDGE_MUL = 16'h0010,
        S_EDGE_V   = 16'h0020,
        S_EDGE_CLS = 16'h0040,
        S_CMP_LO   = 16'h0080,
        S_CMP_HI   = 16'h0100,
        S_CMP_RES  = 16'h0200,
        S_FX_LO    = 16'h0400,
        S_FX_HI    = 16'h0800,
        S_FX_PREP  = 16'h1000,
        S_FX_DIV   = 16'h2000,
        S_FX_END   = 16'h4000,
        S_DONE     = 16'h8000
    } state_t;

    localparam int BW = $clog2(QUO_BITS);

    state_t state_reg;

    logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];
    logic [2*COORD_BITS-1:0] rd_reg;
    logic [AW-1:0]           rd_addr;
    logic                    mem_we;

    logic signed [COORD_BITS-1:0] sx_reg, sy_reg, ax_reg, ay_reg;
    logic signed [DIFF_BITS-1:0]  dx_reg, dy_reg;
    logic [CW-1:0]                k_reg;
    logic [CW-1:0]                j_idx;
    logic                         last_edge;

    logic signed [PROD_BITS-1:0]  p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [V_BITS-1:0]     v1_reg, v2_reg;
    logic [MAG_BITS-1:0]          tsn_reg, tsd_reg, ten_reg, ted_reg;

    logic [MAG_BITS-1:0]          can_reg, cad_reg, cbn_reg, cbd_reg;
    logic                         cmp_final_reg, cmp_start_reg;
    logic [FMAG_BITS-1:0]         l_lo_reg, r_lo_reg, l_hi_reg, r_hi_reg;
    logic [CPROD_BITS-1:0]        lhs, rhs;

    logic [1:0]                   c_reg;
    logic [FMUL_BITS-1:0]         fm_lo_reg, fm_hi_reg;
    logic                         qneg_reg;
    logic [DEN_BITS-1:0]          rem_reg;
    logic [QUO_BITS-1:0]          ush_reg, quo_reg;
    logic [BW-1:0]                bit_reg;
    logic signed [OUT_BITS-1:0]   res_reg [4];
    logic                         vis_reg;

    logic signed [COORD_BITS-1:0] bx, by;
    logic signed [DIFF_BITS-1:0]  ex, ey, sax, say;
    logic signed [COORD_BITS-1:0] fs;
    logic signed [DIFF_BITS-1:0]  fd;
    logic [DIFF_BITS-1:0]         fabs;
    logic [MAG_BITS-1:0]          fn, fden;
    logic [DEN_BITS-1:0]          dd;
    logic [FMAG_BITS-1:0]         fmag;
    logic signed [NUM_BITS-1:0]   num_mag, num_val, num_u;
    logic [DEN_BITS:0]            rem2, rem_diff;
    logic [QUO_BITS:0]            q_ext;
    logic signed [OUT_BITS-1:0]   base;

    assign pop_ready = (state_reg == S_IDLE);
    assign last_edge = (k_reg == CW'(n_edges - 1'b1));
    assign j_idx     = last_edge ? '0 : CW'(k_reg + 1'b1);

    always_comb
    begin
        mem_we  = (state_reg == S_IDLE) && pop_valid && !pop_item.clip && pop_item.slot_ok;
        rd_addr = (state_reg == S_EDGE_RD) ? AW'(j_idx) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[AW'(pop_item.slot)] <= {pop_item.x, pop_item.y};
        end
        rd_reg <= mem[rd_addr];
    end

    always_comb
    begin
        bx   = $signed(rd_reg[2*COORD_BITS-1:COORD_BITS]);
        by   = $signed(rd_reg[COORD_BITS-1:0]);
        ex   = DIFF_BITS'(bx) - DIFF_BITS'(ax_reg);
        ey   = DIFF_BITS'(by) - DIFF_BITS'(ay_reg);
        sax  = DIFF_BITS'(sx_reg) - DIFF_BITS'(ax_reg);
        say  = DIFF_BITS'(sy_reg) - DIFF_BITS'(ay_reg);
        lhs  = {l_hi_reg, {HALF_BITS{1'b0}}} + CPROD_BITS'(l_lo_reg);
        rhs  = {r_hi_reg, {HALF_BITS{1'b0}}} + CPROD_BITS'(r_lo_reg);

        fs   = c_reg[0] ? sy_reg : sx_reg;
        fd   = c_reg[0] ? dy_reg : dx_reg;
        fabs = fd[DIFF_BITS-1] ? DIFF_BITS'(-fd) : DIFF_BITS'(fd);
        fn   = c_reg[1] ? ten_reg : tsn_reg;
        fden = c_reg[1] ? ted_reg : tsd_reg;
        dd   = {fden, 1'b0};
        fmag = {fm_hi_reg, {HALF_BITS{1'b0}}} + FMAG_BITS'(fm_lo_reg);
        num_mag = NUM_BITS'({fmag, {(FRAC_BITS + 1){1'b0}}});
        num_val = (fd[DIFF_BITS-1] ? -num_mag : num_mag) + NUM_BITS'(fden);
        num_u   = num_val[NUM_BITS-1] ? ~num_val : num_val;

        rem2     = {rem_reg, ush_reg[QUO_BITS-1]};
        rem_diff = rem2 - {1'b0, dd};

        q_ext = qneg_reg ? ~{1'b0, quo_reg} : {1'b0, quo_reg};
        base  = OUT_BITS'(fs) <<< FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && (!out_valid || out_ready))
            begin
                out_valid <= 1'b1;
            end
            else if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop_valid && pop_item.clip)
                    begin
                        state_reg <= S_START;
                    end
                end
                S_START:    state_reg <= S_LOAD0;
                S_LOAD0:    state_reg <= S_EDGE_RD;
                S_EDGE_RD:  state_reg <= S_EDGE_MUL;
                S_EDGE_MUL: state_reg <= S_EDGE_V;
                S_EDGE_V:   state_reg <= S_EDGE_CLS;
                S_EDGE_CLS:
                begin
                    if (v1_reg == '0)
                    begin
                        if (v2_reg < 0)
                            state_reg <= S_DONE;
                        else if (last_edge)
                            state_reg <= S_CMP_LO;
                        else
                            state_reg <= S_EDGE_RD;
                    end
                    else if (v1_reg > 0)
                    begin
                        if (v2_reg < 0)
                            state_reg <= S_CMP_LO;
                        else if (last_edge)
                            state_reg <= S_CMP_LO;
                        else
                            state_reg <= S_EDGE_RD;
                    end
                    else
                    begin
                        if (v2_reg < 0)
                            state_reg <= S_DONE;
                        else
                            state_reg <= S_CMP_LO;
                    end
                end
                S_CMP_LO:   state_reg <= S_CMP_HI;
                S_CMP_HI:   state_reg <= S_CMP_RES;
                S_CMP_RES:
                begin
                    if (cmp_final_reg)
                        state_reg <= (lhs > rhs) ? S_DONE : S_FX_LO;
                    else if (last_edge)
                        state_reg <= S_CMP_LO;
                    else
                        state_reg <= S_EDGE_RD;
                end
                S_FX_LO:    state_reg <= S_FX_HI;
                S_FX_HI:    state_reg <= S_FX_PREP;
                S_FX_PREP:  state_reg <= S_FX_DIV;
                S_FX_DIV:
                begin
                    if (bit_reg == BW'(QUO_BITS - 1))
                        state_reg <= S_FX_END;
                end
                S_FX_END:   state_reg <= (c_reg == 2'd3) ? S_DONE : S_FX_LO;
                S_DONE:
                begin
                    if (!out_valid || out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                sx_reg        <= pop_item.x;
                sy_reg        <= pop_item.y;
                dx_reg        <= pop_item.dx;
                dy_reg        <= pop_item.dy;
                k_reg         <= '0;
                tsn_reg       <= '0;
                tsd_reg       <= MAG_BITS'(1);
                ten_reg       <= MAG_BITS'(1);
                ted_reg       <= MAG_BITS'(1);
                cmp_final_reg <= 1'b0;
                c_reg         <= 2'd0;
                vis_reg       <= 1'b0;
            end
            S_LOAD0:
            begin
                ax_reg <= $signed(rd_reg[2*COORD_BITS-1:COORD_BITS]);
                ay_reg <= $signed(rd_reg[COORD_BITS-1:0]);
            end
            S_EDGE_MUL:
            begin
                p0_reg <= ex * dy_reg;
                p1_reg <= ey * dx_reg;
                p2_reg <= ex * say;
                p3_reg <= ey * sax;
                ax_reg <= bx;
                ay_reg <= by;
            end
            S_EDGE_V:
            begin
                v1_reg <= V_BITS'(p0_reg) - V_BITS'(p1_reg);
                v2_reg <= V_BITS'(p2_reg) - V_BITS'(p3_reg);
            end
            S_EDGE_CLS:
            begin
                if (v1_reg > 0 && v2_reg < 0)
                begin
                    can_reg       <= MAG_BITS'(-v2_reg);
                    cad_reg       <= MAG_BITS'(v1_reg);
                    cbn_reg       <= tsn_reg;
                    cbd_reg       <= tsd_reg;
                    cmp_start_reg <= 1'b1;
                    cmp_final_reg <= 1'b0;
                end
                else if (v1_reg < 0)
                begin
                    can_reg       <= MAG_BITS'(v2_reg);
                    cad_reg       <= MAG_BITS'(-v1_reg);
                    cbn_reg       <= ten_reg;
                    cbd_reg       <= ted_reg;
                    cmp_start_reg <= 1'b0;
                    cmp_final_reg <= 1'b0;
                end
                else
                begin
                    can_reg       <= tsn_reg;
                    cad_reg       <= tsd_reg;
                    cbn_reg       <= ten_reg;
                    cbd_reg       <= ted_reg;
                    cmp_final_reg <= last_edge;
                end
            end
            S_CMP_LO:
            begin
                l_lo_reg <= can_reg * cbd_reg[HALF_BITS-1:0];
                r_lo_reg <= cbn_reg * cad_reg[HALF_BITS-1:0];
            end
            S_CMP_HI:
            begin
                l_hi_reg <= can_reg * cbd_reg[MAG_BITS-1:HALF_BITS];
                r_hi_reg <= cbn_reg * cad_reg[MAG_BITS-1:HALF_BITS];
            end
            S_CMP_RES:
            begin
                if (!cmp_final_reg)
                begin
                    if (cmp_start_reg && lhs > rhs)
                    begin
                        tsn_reg <= can_reg;
                        tsd_reg <= cad_reg;
                    end
                    else if (!cmp_start_reg && lhs < rhs)
                    begin
                        ten_reg <= can_reg;
                        ted_reg <= cad_reg;
                    end
                    if (last_edge)
                    begin
                        can_reg       <= (cmp_start_reg && lhs > rhs) ? can_reg : tsn_reg;
                        cad_reg       <= (cmp_start_reg && lhs > rhs) ? cad_reg : tsd_reg;
                        cbn_reg       <= (!cmp_start_reg && lhs < rhs) ? can_reg : ten_reg;
                        cbd_reg       <= (!cmp_start_reg && lhs < rhs) ? cad_reg : ted_reg;
                        cmp_final_reg <= 1'b1;
                    end
                    else
                    begin
                        k_reg <= CW'(k_reg + 1'b1);
                    end
                end
            end
            S_FX_LO:
            begin
                fm_lo_reg <= fabs * fn[HALF_BITS-1:0];
            end
            S_FX_HI:
            begin
                fm_hi_reg <= fabs * fn[MAG_BITS-1:HALF_BITS];
            end
            S_FX_PREP:
            begin
                qneg_reg <= num_val[NUM_BITS-1];
                rem_reg  <= num_u[QUO_BITS+DEN_BITS-1:QUO_BITS];
                ush_reg  <= num_u[QUO_BITS-1:0];
                quo_reg  <= '0;
                bit_reg  <= '0;
            end
            S_FX_DIV:
            begin
                if (!rem_diff[DEN_BITS])
                begin
                    rem_reg <= rem_diff[DEN_BITS-1:0];
                    quo_reg <= {quo_reg[QUO_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem2[DEN_BITS-1:0];
                    quo_reg <= {quo_reg[QUO_BITS-2:0], 1'b0};
                end
                ush_reg <= {ush_reg[QUO_BITS-2:0], 1'b0};
                bit_reg <= BW'(bit_reg + 1'b1);
            end
            S_FX_END:
            begin
                res_reg[c_reg] <= base + $signed(q_ext[OUT_BITS-1:0]);
                c_reg          <= c_reg + 2'd1;
                if (c_reg == 2'd3)
                begin
                    vis_reg <= 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid || out_ready)
                begin
                    visible      <= vis_reg;
                    clip_start_x <= vis_reg ? res_reg[0] : '0;
                    clip_start_y <= vis_reg ? res_reg[1] : '0;
                    clip_end_x   <= vis_reg ? res_reg[2] : '0;
                    clip_end_y   <= vis_reg ? res_reg[3] : '0;
                end
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_EDGE_CLS && v1_reg >= 0 && !(v1_reg > 0 && v2_reg < 0)
            && !last_edge)
        begin
            k_reg <= CW'(k_reg + 1'b1);
        end
    end

endmodule

@@ design/segment_clip_convex_polygon.sv @@
// top level of the convex polygon segment clipper
// usage:
//   request channel (in_valid/in_ready): req_type selects a vertex write, which
//   stores vertex_x/vertex_y at vertex_index, or a clip of start_x/y..end_x/y
//   result channel (out_valid/out_ready): one beat per clip, visible plus the
//   clipped endpoints with 8 fraction bits; a rejected segment returns zeros
//   config channel (cfg_valid/cfg_ready): cfg_data sets the vertex count, write
//   only while no request is in flight; values are clamped to 3..MAX_VERTICES
//   a two-entry queue sits between intake and the clip engine, so requests are
//   taken while a result waits for out_ready
//   engine work: a vertex write is stored straight from idle; a clip of an n-edge
//   polygon holds the engine at most for a per-edge multiply and fraction compare,
//   a final compare and four divides of 26 bit-serial steps each
//   a result register holds the beat while out_ready is low; the engine waits
//   in its last step until that register frees up
//   reset: queue and result register empty, vertex count 3, vertex table
//   contents undefined until written
module segment_clip_convex_polygon #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  req_type,
    input  logic [scc_pkg::IDX_BITS-1:0]          vertex_index,
    input  logic signed [scc_pkg::COORD_BITS-1:0] vertex_x,
    input  logic signed [scc_pkg::COORD_BITS-1:0] vertex_y,
    input  logic signed [scc_pkg::COORD_BITS-1:0] start_x,
    input  logic signed [scc_pkg::COORD_BITS-1:0] start_y,
    input  logic signed [scc_pkg::COORD_BITS-1:0] end_x,
    input  logic signed [scc_pkg::COORD_BITS-1:0] end_y,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  visible,
    output logic signed [scc_pkg::OUT_BITS-1:0]   clip_start_x,
    output logic signed [scc_pkg::OUT_BITS-1:0]   clip_start_y,
    output logic signed [scc_pkg::OUT_BITS-1:0]   clip_end_x,
    output logic signed [scc_pkg::OUT_BITS-1:0]   clip_end_y,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [scc_pkg::CNT_BITS-1:0]          cfg_data
);
    import scc_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic [CNT_BITS-1:0] vcount_reg;
    logic [CW-1:0]       n_edges;
    logic                push_valid, push_ready, pop_valid, pop_ready;
    scc_item_t           push_item, pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= MIN_VERTICES;
        end
        else if (cfg_valid && cfg_ready)
        begin
            vcount_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (vcount_reg < MIN_VERTICES)
            n_edges = CW'(MIN_VERTICES);
        else if ({27'd0, vcount_reg} > 32'(MAX_VERTICES))
            n_edges = CW'(MAX_VERTICES);
        else
            n_edges = CW'(vcount_reg);
    end

    scc_front #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .vertex_index (vertex_index),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_item    (push_item)
    );

    scc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    scc_back #(
        .MAX_VERTICES(MAX_VERTICES),
        .AW          (AW),
        .CW          (CW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .n_edges      (n_edges),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .visible      (visible),
        .clip_start_x (clip_start_x),
        .clip_start_y (clip_start_y),
        .clip_end_x   (clip_end_x),
        .clip_end_y   (clip_end_y)
    );

endmodule
